// ===== src/rope_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotary embedding package
// Shared widths, codes and control types for the rotary pair rotation block.
// ----------------------------------------------------------------------------
package rope_pkg;

  localparam int TILE_WIDTH_DEFAULT = 128;
  localparam int MAX_HEADS_DEFAULT  = 32;

  localparam int ValueW    = 32;
  localparam int TrigW     = 22;
  localparam int HeadW     = 5;
  localparam int PairW     = 6;
  localparam int ActiveW   = 6;
  localparam int CountW    = 32;
  localparam int StatusW   = 2;
  localparam int FracShift = 20;

  localparam int InDataW  = 120;
  localparam int OutDataW = 96;

  typedef enum logic [StatusW-1:0] {
    STATUS_ROTATED  = 2'd0,
    STATUS_LOADED   = 2'd1,
    STATUS_REJECTED = 2'd2
  } rope_status_t;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_ROTATE = 1'b1;

  typedef struct packed {
    logic prod_en;
    logic sum_en;
    logic result_ok;
  } rope_mac_ctl_t;

endpackage

// ===== src/rotary_embedding_pair_rotate.sv =====
// ----------------------------------------------------------------------------
// Rotary embedding pair rotate
// Half-split rotary position embedding with per-pair cosine and sine tables.
// ----------------------------------------------------------------------------
// An accepted transaction passes through three register stages (table read,
// products, sum) and its result then appears on the output. One transaction
// is accepted every cycle while the output is ready, since every stage
// advances each cycle and no unit is shared.
// Reset clears the pipeline valid bits and the completed-head count and sets
// the active head count to one. The tables are not cleared; each entry must
// be loaded before a rotate reads it.
module rotary_embedding_pair_rotate #(
  parameter int TILE_WIDTH = rope_pkg::TILE_WIDTH_DEFAULT,
  parameter int MAX_HEADS  = rope_pkg::MAX_HEADS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // head_index, pair_index, first_value, second_value, cosine_value,
  // sine_value, zero pad
  input  logic [rope_pkg::InDataW-1:0]      s_axis_tdata,
  // kind
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // rotated_first, rotated_second, heads_done
  output logic [rope_pkg::OutDataW-1:0]     m_axis_tdata,
  // status
  output logic [rope_pkg::StatusW-1:0]      m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [rope_pkg::ActiveW-1:0]      cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);
  import rope_pkg::*;

  localparam int HalfWidth = TILE_WIDTH / 2;
  localparam int SlotW     = (HalfWidth > 1) ? $clog2(HalfWidth) : 1;
  localparam int PairCount = 2 ** PairW;
  localparam logic [31:0] MaxHeadsW = 32'(MAX_HEADS);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(HalfWidth - 1);

  // Input fields.
  logic [HeadW-1:0]         in_head;
  logic [PairW-1:0]         in_pair;
  logic signed [ValueW-1:0] in_first;
  logic signed [ValueW-1:0] in_second;
  logic signed [TrigW-1:0]  in_cos;
  logic signed [TrigW-1:0]  in_sin;

  assign in_head   = s_axis_tdata[HeadW-1:0];
  assign in_pair   = s_axis_tdata[HeadW+PairW-1:HeadW];
  assign in_first  = s_axis_tdata[HeadW+PairW+ValueW-1:HeadW+PairW];
  assign in_second = s_axis_tdata[HeadW+PairW+2*ValueW-1:HeadW+PairW+ValueW];
  assign in_cos    = s_axis_tdata[HeadW+PairW+2*ValueW+TrigW-1:HeadW+PairW+2*ValueW];
  assign in_sin    = s_axis_tdata[HeadW+PairW+2*ValueW+2*TrigW-1:
                                  HeadW+PairW+2*ValueW+TrigW];

  // Pair index folded onto the table depth.
  logic [SlotW-1:0] slot_lut [PairCount];
  logic [SlotW-1:0] slot;

  for (genvar k = 0; k < PairCount; k++) begin : g_slot
    localparam int SlotVal = k % HalfWidth;
    assign slot_lut[k] = SlotW'(SlotVal);
  end

  assign slot = slot_lut[in_pair];

  // Configuration.
  logic [ActiveW-1:0] active_heads;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_heads <= ActiveW'(1);
    end else if (cfg_valid && cfg_ready) begin
      active_heads <= cfg_data;
    end
  end

  // Pipeline handshake.
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic accept;

  assign rdy3          = !v3 || m_axis_tready;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Head check and completed-head count.
  logic              head_ok;
  rope_status_t      status_in;
  logic              bump;
  logic [CountW-1:0] heads_count;
  logic [CountW-1:0] heads_count_next;

  assign head_ok = (active_heads != '0) && (32'(active_heads) <= MaxHeadsW) &&
                   ({1'b0, in_head} < active_heads) && (32'(in_head) < MaxHeadsW);

  always_comb begin
    if (s_axis_tuser == KIND_LOAD) begin
      status_in = STATUS_LOADED;
    end else if (head_ok) begin
      status_in = STATUS_ROTATED;
    end else begin
      status_in = STATUS_REJECTED;
    end
  end

  assign bump = accept && (status_in == STATUS_ROTATED) && (slot == LastSlot);
  assign heads_count_next = heads_count + CountW'(bump);

  always_ff @(posedge clk) begin
    if (rst) begin
      heads_count <= '0;
    end else begin
      heads_count <= heads_count_next;
    end
  end

  // Cosine and sine tables, one write and one registered read per cycle while the first stage can advance.
  logic signed [TrigW-1:0] cos_mem [HalfWidth];
  logic signed [TrigW-1:0] sin_mem [HalfWidth];
  logic signed [TrigW-1:0] cos_rd;
  logic signed [TrigW-1:0] sin_rd;

  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == KIND_LOAD) begin
      cos_mem[slot] <= in_cos;
      sin_mem[slot] <= in_sin;
    end
    if (rdy1) begin
      cos_rd <= cos_mem[slot];
      sin_rd <= sin_mem[slot];
    end
  end

  // Stage payloads.
  rope_status_t             s1_status, s2_status, out_status;
  logic [CountW-1:0]        s1_count, s2_count, out_count;
  logic signed [ValueW-1:0] s1_first, s1_second;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_status <= status_in;
      s1_count  <= heads_count_next;
      s1_first  <= in_first;
      s1_second <= in_second;
    end
    if (rdy2) begin
      s2_status <= s1_status;
      s2_count  <= s1_count;
    end
    if (rdy3) begin
      out_status <= s2_status;
      out_count  <= s2_count;
    end
  end

  rope_mac_ctl_t            mac_ctl;
  logic signed [ValueW-1:0] rotated_first;
  logic signed [ValueW-1:0] rotated_second;

  assign mac_ctl.prod_en   = rdy2;
  assign mac_ctl.sum_en    = rdy3;
  assign mac_ctl.result_ok = (s2_status == STATUS_ROTATED);

  rope_mac u_mac (
    .clk            (clk),
    .ctl            (mac_ctl),
    .first_value    (s1_first),
    .second_value   (s1_second),
    .cosine_value   (cos_rd),
    .sine_value     (sin_rd),
    .rotated_first  (rotated_first),
    .rotated_second (rotated_second)
  );

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {out_count, rotated_second, rotated_first};
  assign m_axis_tuser  = out_status;

`ifndef ASSERT_OFF
  // Only results of rotated pairs carry nonzero data.
  a_zero_unless_rotated: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_status != STATUS_ROTATED |->
      rotated_first == '0 && rotated_second == '0)
    else $error("nonzero rotated data on a load or rejected result");

  // The head count only moves on an accepted rotate transaction.
  a_count_moves_on_rotate: assert property (@(posedge clk) disable iff (rst)
    heads_count != $past(heads_count) |->
      $past(accept) && $past(s_axis_tuser) == KIND_ROTATE)
    else $error("head count changed without a rotate transaction");

  // A stalled first stage keeps its captured count.
  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1 && $stable(s1_count) && $stable(s1_status))
    else $error("first stage payload changed while stalled");
`endif

endmodule

// ===== src/rope_mac.sv =====
// ----------------------------------------------------------------------------
// Rotary embedding multiply-accumulate
// Registers the four cross products, then forms both rotated results, shifting out the Q2.20 fraction bits.
// ----------------------------------------------------------------------------
module rope_mac (
  input  logic                                clk,
  input  rope_pkg::rope_mac_ctl_t             ctl,
  input  logic signed [rope_pkg::ValueW-1:0]  first_value,
  input  logic signed [rope_pkg::ValueW-1:0]  second_value,
  input  logic signed [rope_pkg::TrigW-1:0]   cosine_value,
  input  logic signed [rope_pkg::TrigW-1:0]   sine_value,
  output logic signed [rope_pkg::ValueW-1:0]  rotated_first,
  output logic signed [rope_pkg::ValueW-1:0]  rotated_second
);
  import rope_pkg::*;

  localparam int ProdW = ValueW + TrigW;
  localparam int SumW  = ProdW + 1;
  localparam int ResLo = FracShift;
  localparam int ResHi = FracShift + ValueW - 1;

  logic signed [ProdW-1:0] prod_ac;
  logic signed [ProdW-1:0] prod_bs;
  logic signed [ProdW-1:0] prod_bc;
  logic signed [ProdW-1:0] prod_as;
  logic signed [SumW-1:0]  sum_first;
  logic signed [SumW-1:0]  sum_second;

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_ac <= ProdW'(first_value * cosine_value);
      prod_bs <= ProdW'(second_value * sine_value);
      prod_bc <= ProdW'(second_value * cosine_value);
      prod_as <= ProdW'(first_value * sine_value);
    end
  end

  assign sum_first  = SumW'(prod_ac) - SumW'(prod_bs);
  assign sum_second = SumW'(prod_bc) + SumW'(prod_as);

  // The arithmetic shift and the wrap to 32 bits reduce to one bit slice.
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      if (ctl.result_ok) begin
        rotated_first  <= sum_first[ResHi:ResLo];
        rotated_second <= sum_second[ResHi:ResLo];
      end else begin
        rotated_first  <= '0;
        rotated_second <= '0;
      end
    end
  end

endmodule

// ===== test/rotary_embedding_pair_rotate_test.sv =====
// ----------------------------------------------------------------------------
// Rotary embedding pair rotate testbench
// Streams table loads and pair rotations through the block under several head
// counts, predicts each result from an internal model of the tables and the
// completed-head count or takes it from the scripted rows, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module rotary_embedding_pair_rotate_test;
  import rope_pkg::*;

  localparam int HALF_PAIRS   = TILE_WIDTH_DEFAULT / 2;
  localparam int LAST_PAIR    = HALF_PAIRS - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int BACKLOG_AT   = 400;
  localparam int BACKLOG_LEN  = 400;

  typedef enum logic {
    ROW_ITEM  = 1'b0,
    ROW_HEADS = 1'b1
  } row_op_t;

  typedef struct packed {
    logic signed [ValueW-1:0] first;
    logic signed [ValueW-1:0] second;
    rope_status_t             status;
    logic [CountW-1:0]        heads_done;
  } pair_result_t;

  typedef struct packed {
    row_op_t                  op;
    logic [ActiveW-1:0]       heads_cfg;
    logic                     kind;
    logic [HeadW-1:0]         head;
    logic [PairW-1:0]         pair;
    logic signed [ValueW-1:0] a;
    logic signed [ValueW-1:0] b;
    logic signed [TrigW-1:0]  c;
    logic signed [TrigW-1:0]  s;
    logic                     typed;
    pair_result_t             result;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [StatusW-1:0]    m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [ActiveW-1:0]    cfg_data = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;

  // Predictor state.
  logic signed [TrigW-1:0] cos_entries [HALF_PAIRS];
  logic signed [TrigW-1:0] sin_entries [HALF_PAIRS];
  logic [CountW-1:0]       heads_completed = '0;
  logic [ActiveW-1:0]      active_heads_setting = 6'd1;

  pair_result_t expected_results [$];
  logic         item_has_typed = 1'b0;
  pair_result_t item_typed = '0;
  int           inputs_accepted = 0;
  int           results_seen = 0;
  int           items_sent = 0;
  int           errors = 0;
  int           cycle_count = 0;
  bit           quiet_tail = 0;
  bit           backlog_done = 0;
  bit [HALF_PAIRS-1:0] loaded = '0;
  script_row_t  script [23];

  rotary_embedding_pair_rotate DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_data     (cfg_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Both products are exact in 64 bits before the Q20 scaling shift.
  function automatic pair_result_t rotate_pair(logic signed [ValueW-1:0] a,
                                               logic signed [ValueW-1:0] b,
                                               logic signed [TrigW-1:0] c,
                                               logic signed [TrigW-1:0] s);
    longint       acc_first;
    longint       acc_second;
    pair_result_t res;
    acc_first  = (longint'(a) * longint'(c) - longint'(b) * longint'(s)) >>> FracShift;
    acc_second = (longint'(b) * longint'(c) + longint'(a) * longint'(s)) >>> FracShift;
    res = '0;
    res.first  = acc_first[ValueW-1:0];
    res.second = acc_second[ValueW-1:0];
    res.status = STATUS_ROTATED;
    return res;
  endfunction

  function automatic pair_result_t apply_pair_item(logic kind, logic [InDataW-1:0] d);
    logic [HeadW-1:0] head;
    logic [PairW-1:0] pair;
    pair_result_t     res;
    head = d[4:0];
    pair = d[10:5];
    res  = '0;
    if (kind == KIND_LOAD) begin
      cos_entries[pair] = d[96:75];
      sin_entries[pair] = d[118:97];
      res.status = STATUS_LOADED;
    end else if (active_heads_setting == 0 || active_heads_setting > MAX_HEADS_DEFAULT ||
                 head >= active_heads_setting) begin
      res.status = STATUS_REJECTED;
    end else begin
      res = rotate_pair(d[42:11], d[74:43], cos_entries[pair], sin_entries[pair]);
      if (pair == LAST_PAIR) begin
        heads_completed = heads_completed + 1;
      end
    end
    res.heads_done = heads_completed;
    return res;
  endfunction

  always @(posedge clk) begin : check_results
    pair_result_t predicted;
    pair_result_t got;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predicted = apply_pair_item(s_axis_tuser, s_axis_tdata);
      if (item_has_typed) begin
        predicted = item_typed;
      end
      expected_results.push_back(predicted);
      inputs_accepted <= inputs_accepted + 1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      got.first      = m_axis_tdata[31:0];
      got.second     = m_axis_tdata[63:32];
      got.status     = rope_status_t'(m_axis_tuser);
      got.heads_done = m_axis_tdata[95:64];
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        predicted = expected_results.pop_front();
        if (got.first !== predicted.first) begin
          errors++;
          $display("%0t: rotated_first expected %h actual %h", $time, predicted.first,
                   got.first);
        end
        if (got.second !== predicted.second) begin
          errors++;
          $display("%0t: rotated_second expected %h actual %h", $time, predicted.second,
                   got.second);
        end
        if (got.status !== predicted.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, predicted.status,
                   got.status);
        end
        if (got.heads_done !== predicted.heads_done) begin
          errors++;
          $display("%0t: heads_done expected %h actual %h", $time, predicted.heads_done,
                   got.heads_done);
        end
      end
    end
  end

  // Output pacing: random stall bursts, one long hold-off to back the pipeline
  // up into the input, and no stalls once the tail of the run begins.
  initial begin : sink_pacing
    @(posedge clk);
    forever begin
      if (!backlog_done && inputs_accepted >= BACKLOG_AT) begin
        backlog_done = 1;
        m_axis_tready <= 1'b0;
        repeat (BACKLOG_LEN) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic script_row_t item_row(logic kind, logic [HeadW-1:0] head,
                                           logic [PairW-1:0] pair,
                                           logic signed [ValueW-1:0] a,
                                           logic signed [ValueW-1:0] b,
                                           logic signed [TrigW-1:0] c,
                                           logic signed [TrigW-1:0] s);
    script_row_t r;
    r      = '0;
    r.op   = ROW_ITEM;
    r.kind = kind;
    r.head = head;
    r.pair = pair;
    r.a    = a;
    r.b    = b;
    r.c    = c;
    r.s    = s;
    return r;
  endfunction

  function automatic script_row_t with_result(script_row_t r, logic [ValueW-1:0] first,
                                              logic [ValueW-1:0] second,
                                              rope_status_t status,
                                              logic [CountW-1:0] heads_done);
    r.typed             = 1'b1;
    r.result.first      = first;
    r.result.second     = second;
    r.result.status     = status;
    r.result.heads_done = heads_done;
    return r;
  endfunction

  function automatic script_row_t heads_row(logic [ActiveW-1:0] value);
    script_row_t r;
    r           = '0;
    r.op        = ROW_HEADS;
    r.heads_cfg = value;
    return r;
  endfunction

  function automatic logic signed [ValueW-1:0] rand_element();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [TrigW-1:0] rand_trig();
    int v;
    v = int'($urandom_range(0, 2097152)) - 1048576;
    case ($urandom_range(0, 7))
      0: return 22'sh10_0000;
      1: return 22'sh30_0000;
      2: return '0;
      3: return $urandom();
      default: return v[TrigW-1:0];
    endcase
  endfunction

  function automatic logic [HeadW-1:0] pick_head();
    if (active_heads_setting == 0 || active_heads_setting > MAX_HEADS_DEFAULT ||
        $urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 31);
    end
    return $urandom_range(0, active_heads_setting - 1);
  endfunction

  function automatic logic [PairW-1:0] pick_loaded_pair();
    logic [PairW-1:0] p;
    if ($urandom_range(0, 5) == 0) begin
      return LAST_PAIR;
    end
    do begin
      p = $urandom_range(0, LAST_PAIR);
    end while (!loaded[p]);
    return p;
  endfunction

  task automatic send_pair_item(logic kind, logic [HeadW-1:0] head, logic [PairW-1:0] pair,
                                logic signed [ValueW-1:0] a, logic signed [ValueW-1:0] b,
                                logic signed [TrigW-1:0] c, logic signed [TrigW-1:0] s,
                                logic has_typed, pair_result_t typed_res);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tdata   <= {1'b0, s, c, b, a, pair, head};
    s_axis_tuser   <= kind;
    s_axis_tvalid  <= 1'b1;
    item_has_typed <= has_typed;
    item_typed     <= typed_res;
    do @(posedge clk); while (!s_axis_tready);
    if (kind == KIND_LOAD) begin
      loaded[pair] = 1'b1;
    end
    items_sent++;
  endtask

  task automatic load_entry(logic [PairW-1:0] pair);
    send_pair_item(KIND_LOAD, $urandom(), pair, rand_element(), rand_element(), rand_trig(),
                   rand_trig(), 1'b0, '0);
  endtask

  task automatic rotate_entry(logic [HeadW-1:0] head, logic [PairW-1:0] pair);
    send_pair_item(KIND_ROTATE, head, pair, rand_element(), rand_element(), $urandom(),
                   $urandom(), 1'b0, '0);
  endtask

  // The register changes only with the pipeline empty.
  task automatic write_heads(logic [ActiveW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_heads_setting = value;
  endtask

  initial begin : stimulus
    logic [ActiveW-1:0] plan [8];
    logic [ActiveW-1:0] setting;
    logic [HeadW-1:0]   head;
    int                 target;
    int                 quota;
    int                 first;

    script = '{
      with_result(item_row(KIND_LOAD, 0, 0, 0, 0, 22'sh10_0000, 0),
                  0, 0, STATUS_LOADED, 0),
      with_result(item_row(KIND_LOAD, 0, LAST_PAIR, 0, 0, 0, 22'sh10_0000),
                  0, 0, STATUS_LOADED, 0),
      with_result(item_row(KIND_LOAD, 0, 1, 0, 0, 22'sh30_0000, 22'sh30_0000),
                  0, 0, STATUS_LOADED, 0),
      with_result(item_row(KIND_LOAD, 0, 2, 0, 0, 22'sh1f_ffff, 22'sh20_0000),
                  0, 0, STATUS_LOADED, 0),
      // Unity cosine passes the elements through unchanged.
      with_result(item_row(KIND_ROTATE, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0),
                  32'h7fff_ffff, 32'h8000_0000, STATUS_ROTATED, 0),
      with_result(item_row(KIND_ROTATE, 1, 0, 1, 1, 0, 0), 0, 0, STATUS_REJECTED, 0),
      with_result(item_row(KIND_ROTATE, 31, LAST_PAIR, 1, 1, 0, 0),
                  0, 0, STATUS_REJECTED, 0),
      // Unity sine swaps the pair and negates the first result.
      with_result(item_row(KIND_ROTATE, 0, LAST_PAIR, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0),
                  32'h8000_0001, 32'h8000_0000, STATUS_ROTATED, 1),
      item_row(KIND_ROTATE, 0, 1, -32'sd1, -32'sd1, 0, 0),
      item_row(KIND_ROTATE, 0, 2, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0),
      with_result(item_row(KIND_LOAD, 31, 0, -32'sd1, -32'sd1, -22'sd1, 22'sd1),
                  0, 0, STATUS_LOADED, 1),
      item_row(KIND_ROTATE, 0, 0, 32'sd12345, -32'sd54321, 0, 0),
      heads_row(6'd32),
      with_result(item_row(KIND_ROTATE, 31, LAST_PAIR, 1, 1, 0, 0),
                  32'hffff_ffff, 1, STATUS_ROTATED, 2),
      item_row(KIND_ROTATE, 30, 1, 32'sh0001_8000, -32'sh0003_0000, -22'sd1, -22'sd1),
      heads_row(6'd0),
      with_result(item_row(KIND_ROTATE, 0, 0, 1, 1, 0, 0), 0, 0, STATUS_REJECTED, 2),
      heads_row(6'd63),
      with_result(item_row(KIND_ROTATE, 0, 1, 1, 1, 0, 0), 0, 0, STATUS_REJECTED, 2),
      heads_row(6'd33),
      with_result(item_row(KIND_ROTATE, 5, 2, 1, 1, 0, 0), 0, 0, STATUS_REJECTED, 2),
      heads_row(6'd1),
      with_result(item_row(KIND_ROTATE, 0, LAST_PAIR, 0, 0, 0, 0),
                  0, 0, STATUS_ROTATED, 3)
    };
    plan = '{6'd32, 6'd1, 6'd0, 6'd7, 6'd63, 6'd32, 6'd33, 6'd0};
    plan[6] = $urandom_range(33, 63);
    plan[7] = $urandom_range(2, 31);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].op == ROW_HEADS) begin
        write_heads(script[i].heads_cfg);
      end else begin
        send_pair_item(script[i].kind, script[i].head, script[i].pair, script[i].a,
                       script[i].b, script[i].c, script[i].s, script[i].typed,
                       script[i].result);
      end
    end

    foreach (plan[phase]) begin
      setting = plan[phase];
      write_heads(setting);
      quota  = (setting == 0 || setting > MAX_HEADS_DEFAULT) ? 80 : 290;
      target = items_sent + quota;
      while (items_sent < target) begin
        case ($urandom_range(0, 3))
          0: begin
            repeat ($urandom_range(1, 8)) load_entry($urandom_range(0, LAST_PAIR));
          end
          1, 2: begin
            // A head swept up to its last pair, loading any entry still unwritten.
            head  = pick_head();
            first = $urandom_range(0, 3) == 0 ? $urandom_range(0, LAST_PAIR) :
                                                $urandom_range(LAST_PAIR - 12, LAST_PAIR);
            for (int p = first; p <= LAST_PAIR; p++) begin
              if (!loaded[p]) begin
                load_entry(p);
              end
              rotate_entry(head, p);
            end
          end
          default: begin
            if ($urandom_range(0, 1) == 0) begin
              load_entry($urandom_range(0, LAST_PAIR));
            end else begin
              rotate_entry($urandom_range(0, 31), pick_loaded_pair());
            end
          end
        endcase
        if (phase == 7 && items_sent > target - 150) begin
          quiet_tail = 1;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== rotary_embedding_pair_rotate.f =====
src/rope_pkg.sv
src/rope_mac.sv
src/rotary_embedding_pair_rotate.sv
test/rotary_embedding_pair_rotate_test.sv
